// ----- rtl/tks_pkg.sv -----
// Shared types and constants for the term key radix sorter.
// Used by tks_front, tks_jobq, tks_back and term_key_radix_sorter.
package tks_pkg;

  localparam int unsigned KEY_WIDTH = 64;
  localparam int unsigned CNT_WIDTH = 7;  // holds any set size up to 64
  localparam int unsigned ADDR_WIDTH = 4;
  localparam int unsigned DATA_WIDTH = 64;

  // Register indexes of the configuration port.
  localparam logic REG_ORDER_MASK = 1'b0;

  // One finished set waiting for, or being worked by, the back end.
  typedef struct packed {
    logic                 bank;
    logic [CNT_WIDTH-1:0] count;
    logic                 overflow;
    logic [KEY_WIDTH-1:0] mask;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

endpackage

// ----- rtl/tks_front.sv -----
// Front end: accepts terms, assigns them store slots and posts finished sets.
// Depends on tks_pkg.
module tks_front #(
  parameter int unsigned MAX_TERMS  = 64,
  parameter int unsigned COEF_WIDTH = 64,
  parameter int unsigned IDXW       = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tks_pkg::KEY_WIDTH-1:0] exponent_key_i,
  input  logic [COEF_WIDTH-1:0]         coefficient_i,
  input  logic                         last_term_i,
  input  logic [tks_pkg::KEY_WIDTH-1:0] mask_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output tks_pkg::job_t                job_o,
  output logic                         we_o,
  output logic [IDXW:0]                waddr_o,
  output logic [tks_pkg::KEY_WIDTH+COEF_WIDTH-1:0] wdata_o
);
  import tks_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          bank_q, bank_d;
  logic          accept, full;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CW'(MAX_TERMS));

  assign we_o    = accept && !full;
  assign waddr_o = {bank_q, cnt_q[IDXW-1:0]};
  assign wdata_o = {coefficient_i, exponent_key_i};

  assign push_o         = accept && last_term_i;
  assign job_o.bank     = bank_q;
  assign job_o.count    = full ? CNT_WIDTH'(cnt_q) : CNT_WIDTH'(cnt_q + CW'(1));
  assign job_o.overflow = ovf_q || full;
  assign job_o.mask     = mask_i;

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    bank_d = bank_q;
    if (accept) begin
      if (last_term_i) begin
        cnt_d  = '0;
        ovf_d  = 1'b0;
        bank_d = !bank_q;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
    end
  end

endmodule

// ----- rtl/tks_jobq.sv -----
// Two-entry queue of finished sets between the front and back ends.
// Depends on tks_pkg.
module tks_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tks_pkg::job_t job_i,
  input  logic          pop_i,
  output tks_pkg::job_t head_o,
  output logic          avail_o,
  output logic          full_o
);
  import tks_pkg::*;

  job_t       ent_q [2];
  logic       rp_q, wp_q;
  logic [1:0] cnt_q;

  assign head_o  = ent_q[rp_q];
  assign avail_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= 1'b0;
      wp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("job queue overrun");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o) else $error("job queue underrun");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("job queue count out of range");

endmodule

// ----- rtl/tks_back.sv -----
// Back end: holds the term store and emits each set by repeated max selection.
// Depends on tks_pkg.
module tks_back #(
  parameter int unsigned MAX_TERMS  = 64,
  parameter int unsigned COEF_WIDTH = 64,
  parameter int unsigned IDXW       = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [IDXW:0]                waddr_i,
  input  logic [tks_pkg::KEY_WIDTH+COEF_WIDTH-1:0] wdata_i,
  input  tks_pkg::job_t                job_i,
  input  logic                         job_avail_i,
  output logic                         job_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tks_pkg::KEY_WIDTH-1:0] sorted_key_o,
  output logic [COEF_WIDTH-1:0]         sorted_coefficient_o,
  output logic                         end_of_run_o,
  output logic                         overflowed_o
);
  import tks_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_TERMS + 1);
  // Each bank spans a full power of two so that {bank, index} always lands inside.
  localparam int unsigned DEPTH = 2 ** (IDXW + 1);
  localparam int unsigned RW    = KEY_WIDTH + COEF_WIDTH;

  logic [RW-1:0]        mem [DEPTH];
  logic [RW-1:0]        rdata_q;
  logic [IDXW:0]        raddr;

  back_state_e          state_q, state_d;
  logic [CW-1:0]        ic_q, ic_d;
  logic [CW-1:0]        em_q, em_d;
  logic                 rv_q, rv_d;
  logic [IDXW-1:0]      ridx_q;
  logic [MAX_TERMS-1:0] done_q, done_d;
  logic                 have_q, have_d;
  logic [IDXW-1:0]      bidx_q;
  logic [RW-1:0]        best_q;
  logic                 ov_q, ov_d;

  logic [CW-1:0]        n;
  logic                 scan_end, take, issue, fire;
  logic [KEY_WIDTH-1:0] rkey;

  assign n        = job_i.count[CW-1:0];
  assign issue    = (state_q == ST_SCAN) && (ic_q != n);
  assign scan_end = (state_q == ST_SCAN) && (ic_q == n) && !rv_q;
  assign raddr    = {job_i.bank, ic_q[IDXW-1:0]};
  assign rkey     = rdata_q[KEY_WIDTH-1:0];
  // Strictly greater keeps the earliest of equal keys, so ties leave in load order.
  assign take = rv_q && !done_q[ridx_q] &&
                (!have_q || ((rkey ^ job_i.mask) > (best_q[KEY_WIDTH-1:0] ^ job_i.mask)));
  assign fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d   = state_q;
    ic_d      = ic_q;
    em_d      = em_q;
    rv_d      = issue;
    done_d    = done_q;
    have_d    = have_q || take;
    ov_d      = ov_q;
    job_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_avail_i) begin
          state_d = ST_SCAN;
          ic_d    = '0;
          em_d    = '0;
          have_d  = 1'b0;
          done_d  = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          ic_d = ic_q + CW'(1);
        end
        if (scan_end) begin
          state_d        = ST_EMIT;
          done_d[bidx_q] = 1'b1;
          ov_d           = (em_q + CW'(1) == n);
        end
      end
      ST_EMIT: begin
        if (fire) begin
          if (ov_q) begin
            state_d   = ST_IDLE;
            job_pop_o = 1'b1;
          end else begin
            state_d = ST_SCAN;
            ic_d    = '0;
            have_d  = 1'b0;
            em_d    = em_q + CW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ic_q    <= '0;
      em_q    <= '0;
      rv_q    <= 1'b0;
      done_q  <= '0;
      have_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ic_q    <= ic_d;
      em_q    <= em_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
      have_q  <= have_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ic_q[IDXW-1:0];
    if (take) begin
      best_q <= rdata_q;
      bidx_q <= ridx_q;
    end
  end

  assign out_valid_o          = (state_q == ST_EMIT);
  assign sorted_key_o         = best_q[KEY_WIDTH-1:0];
  assign sorted_coefficient_o = best_q[RW-1:KEY_WIDTH];
  assign end_of_run_o         = ov_q;
  assign overflowed_o         = job_i.overflow;

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> state_q == ST_SCAN) else $error("read data outside a scan");
  a_found_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_end |-> have_q) else $error("scan ended without a candidate");
  a_marks_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_end |=> done_q[$past(bidx_q)]) else $error("emitted term not marked");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> fire && end_of_run_o) else $error("set retired early");

endmodule

// ----- rtl/term_key_radix_sorter.sv -----
// Top level of the term key radix sorter: config register, front end, set queue
// and back end. Depends on tks_pkg, tks_front, tks_jobq and tks_back.
//
//   channel   signals                                    direction
//   in        in_valid_i/in_ready_o, key, coef, last     request in
//   out       out_valid_o/out_ready_i, key, coef, flags  request out
//   cfg       psel, penable, pwrite, paddr, pwdata        APB register port
//
// Loading accepts a new term whenever in_ready_o is high. Each output term
// of a set is found by a full pass over the set through the single read port
// of the term store, one entry per cycle. Two store banks let the next set
// load while the current one drains; loading stalls only when both banks
// hold unfinished sets. No clearing pass after reset.
module term_key_radix_sorter #(
  parameter int unsigned MAX_TERMS  = 64,
  parameter int unsigned COEF_WIDTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [tks_pkg::KEY_WIDTH-1:0]       exponent_key_i,
  input  logic [COEF_WIDTH-1:0]               coefficient_i,
  input  logic                                last_term_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tks_pkg::KEY_WIDTH-1:0]       sorted_key_o,
  output logic [COEF_WIDTH-1:0]               sorted_coefficient_o,
  output logic                                end_of_run_o,
  output logic                                overflowed_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tks_pkg::ADDR_WIDTH-1:0]      paddr,
  input  logic [tks_pkg::DATA_WIDTH-1:0]      pwdata,
  output logic [tks_pkg::DATA_WIDTH-1:0]      prdata,
  output logic                                pready
);
  import tks_pkg::*;

  localparam int unsigned IDXW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic [KEY_WIDTH-1:0]        mask_q;
  logic                        push, pop, q_full, q_avail, we;
  job_t                        job_in, job_head;
  logic [IDXW:0]               waddr;
  logic [KEY_WIDTH+COEF_WIDTH-1:0] wdata;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_ORDER_MASK) ? mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[3] == REG_ORDER_MASK)) begin
      mask_q <= pwdata;
    end
  end

  tks_front #(
    .MAX_TERMS (MAX_TERMS),
    .COEF_WIDTH(COEF_WIDTH),
    .IDXW      (IDXW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .exponent_key_i(exponent_key_i),
    .coefficient_i (coefficient_i),
    .last_term_i   (last_term_i),
    .mask_i        (mask_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (job_in),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata)
  );

  tks_jobq u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .head_o (job_head),
    .avail_o(q_avail),
    .full_o (q_full)
  );

  tks_back #(
    .MAX_TERMS (MAX_TERMS),
    .COEF_WIDTH(COEF_WIDTH),
    .IDXW      (IDXW)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .we_i                (we),
    .waddr_i             (waddr),
    .wdata_i             (wdata),
    .job_i               (job_head),
    .job_avail_i         (q_avail),
    .job_pop_o           (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .sorted_key_o        (sorted_key_o),
    .sorted_coefficient_o(sorted_coefficient_o),
    .end_of_run_o        (end_of_run_o),
    .overflowed_o        (overflowed_o)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for term_key_radix_sorter: directed and random sets of terms,
// an in-bench sorting predictor and a scoreboard of expected sorted terms.
// Depends on tks_pkg and the term_key_radix_sorter RTL.
`timescale 1ns / 1ps

module tb_top;
  import tks_pkg::*;

  localparam int unsigned NTERMS = 64;
  localparam int unsigned CW = 64;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    logic [KEY_WIDTH-1:0] key;
    logic [CW-1:0]        coef;
    logic                 last;
  } term_t;

  typedef struct {
    logic [KEY_WIDTH-1:0] key;
    logic [CW-1:0]        coef;
    logic                 eor;
    logic                 ovf;
  } sorted_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [KEY_WIDTH-1:0]  exponent_key_i = '0;
  logic [CW-1:0]         coefficient_i = '0;
  logic                  last_term_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [KEY_WIDTH-1:0]  sorted_key_o;
  logic [CW-1:0]         sorted_coefficient_o;
  logic                  end_of_run_o;
  logic                  overflowed_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  term_key_radix_sorter #(.MAX_TERMS(NTERMS), .COEF_WIDTH(CW)) dut (.*);

  always #4 clk_i = ~clk_i;

  term_t                pending_terms[$];
  sorted_t              expected_sorted[$];
  logic [KEY_WIDTH-1:0] mdl_mask = '0;
  logic [KEY_WIDTH-1:0] mdl_keys[NTERMS];
  logic [CW-1:0]        mdl_coefs[NTERMS];
  int unsigned          mdl_count = 0;
  logic                 mdl_ovf = 1'b0;
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          in_gap = 0;
  int unsigned          out_gap = 0;
  logic                 drv_busy = 1'b0;
  logic [KEY_WIDTH-1:0] key_pool[4];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Loads one term and, on the end of a set, queues the set in sorted order.
  task automatic sort_term(input term_t t);
    int unsigned order[NTERMS];
    int unsigned i, j, k;
    sorted_t     s;
    if (mdl_count < NTERMS) begin
      mdl_keys[mdl_count] = t.key;
      mdl_coefs[mdl_count] = t.coef;
      mdl_count++;
    end else begin
      mdl_ovf = 1'b1;
    end
    if (!t.last) return;
    for (i = 0; i < mdl_count; i++) begin
      j = i;
      while (j > 0 && ((mdl_keys[i] ^ mdl_mask) > (mdl_keys[order[j-1]] ^ mdl_mask))) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (k = 0; k < mdl_count; k++) begin
      s.key = mdl_keys[order[k]];
      s.coef = mdl_coefs[order[k]];
      s.eor = (k + 1 == mdl_count);
      s.ovf = mdl_ovf;
      expected_sorted.push_back(s);
    end
    mdl_count = 0;
    mdl_ovf = 1'b0;
  endtask

  // Driver: one request in flight, with a random idle gap before each.
  always @(posedge clk_i) begin
    term_t t;
    if (rst_ni) begin
      if (drv_busy && in_ready_o) begin
        t = pending_terms.pop_front();
        sort_term(t);
        drv_busy = 1'b0;
        in_gap = $urandom_range(0, 3);
      end
      if (!drv_busy) begin
        if (in_gap > 0) in_gap--;
        else if (pending_terms.size() > 0) begin
          t = pending_terms[0];
          exponent_key_i <= t.key;
          coefficient_i <= t.coef;
          last_term_i <= t.last;
          drv_busy = 1'b1;
        end
      end
      in_valid_i <= drv_busy;
    end
  end

  // Monitor: compares each accepted sorted term with the oldest expectation.
  always @(posedge clk_i) begin
    sorted_t s;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_sorted.size() == 0) begin
          report_mismatch("unexpected term, key", sorted_key_o, 64'd0);
        end else begin
          s = expected_sorted.pop_front();
          if (sorted_key_o !== s.key) report_mismatch("sorted_key", sorted_key_o, s.key);
          if (sorted_coefficient_o !== s.coef)
            report_mismatch("sorted_coefficient", sorted_coefficient_o, s.coef);
          if (end_of_run_o !== s.eor)
            report_mismatch("end_of_run", {63'd0, end_of_run_o}, {63'd0, s.eor});
          if (overflowed_o !== s.ovf)
            report_mismatch("overflowed", {63'd0, overflowed_o}, {63'd0, s.ovf});
        end
        out_gap = $urandom_range(0, 3);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_write(input logic [ADDR_WIDTH-1:0] addr, input logic [63:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // Register index 0 is the only one; the model updates the mask only for address 0.
    if (addr == 0) mdl_mask = data;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_term(input logic [63:0] key, input logic [63:0] coef, input logic last);
    term_t t;
    t.key = key;
    t.coef = coef;
    t.last = last;
    pending_terms.push_back(t);
  endtask

  // Random set; keys often come from a small pool so that ties occur.
  task automatic add_random_set(input int unsigned n);
    int unsigned i;
    logic [63:0] k;
    logic [3:0]  nib;
    for (i = 0; i < n; i++) begin
      nib = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: k = key_pool[$urandom_range(0, 3)];
        1: k = rand64() & {16{nib}};
        default: k = rand64();
      endcase
      add_term(k, rand64(), i + 1 == n);
    end
  endtask

  task automatic drain();
    wait (pending_terms.size() == 0 && !drv_busy && expected_sorted.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    int unsigned items;
    int unsigned n;
    int unsigned ph;
    foreach (key_pool[i]) key_pool[i] = rand64();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets under the reset mask.
    add_term(64'd0, 64'd0, 1'b1);
    add_term(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_term(64'd0, 64'h1, 1'b0);
    add_term(64'h8000_0000_0000_0000, 64'h2, 1'b0);
    add_term(64'd1, 64'h3, 1'b1);
    // Equal keys must leave in load order.
    add_term(64'h55, 64'ha, 1'b0);
    add_term(64'h55, 64'hb, 1'b0);
    add_term(64'h54, 64'hc, 1'b0);
    add_term(64'h55, 64'hd, 1'b1);
    drain();

    apb_write(4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_term(64'd0, 64'h5, 1'b0);
    add_term(64'hFFFF_FFFF_FFFF_FFFF, 64'h6, 1'b0);
    add_term(64'h0000_0000_FFFF_FFFF, 64'h7, 1'b1);
    drain();

    // A write to an unmapped address leaves the mask alone.
    apb_write(4'd8, rand64());
    apb_write(4'd0, 64'hAAAA_AAAA_0000_FFFF);
    add_random_set(6);
    drain();

    // Full store: two terms past capacity, the dropped last one ends the set.
    apb_write(4'd0, rand64());
    add_random_set(66);
    drain();

    // Random phases run until at least 36 random terms have been loaded.
    items = 0;
    ph = 0;
    while (items < 36) begin
      case (ph % 4)
        0: apb_write(4'd0, 64'd0);
        1: apb_write(4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        default: apb_write(4'd0, rand64());
      endcase
      repeat ($urandom_range(2, 4)) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        add_random_set(n);
        items += n;
      end
      drain();
      ph++;
    end

    drain();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tks_pkg.sv
rtl/tks_front.sv
rtl/tks_jobq.sv
rtl/tks_back.sv
rtl/term_key_radix_sorter.sv
verif/tb_top.sv
